FILE: design/seven_segment_two_wire_frame_writer_unit_assert.svh
// Assertion macros shared by the frame writer's checker.
// Each macro expands to one labelled concurrent assertion clocked on clk, disabled in rst.
`ifndef SEVEN_SEGMENT_TWO_WIRE_FRAME_WRITER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_TWO_WIRE_FRAME_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SSWFW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame writer check failed");

// Next-cycle implication.
`define SSWFW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame writer check failed");

`endif

FILE: design/sswfw_pkg.sv
// Types, constants and helper functions for the two-wire seven-segment frame writer.
// Used by every module of the block; depends on nothing.
package sswfw_pkg;

  localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
  localparam logic [7:0] ADDR_BASE      = 8'hc0;
  localparam logic [7:0] CONTROL_RESET  = 8'h8a;

  localparam logic [2:0] LAST_TRANSACTION = 3'd5;
  localparam int         START_TICKS      = 3;
  localparam int         SLOT_TICKS       = 28;
  localparam int         BIT_TICKS        = 24;

  localparam logic [5:0] BODY_END_ONE = 6'(START_TICKS + SLOT_TICKS);
  localparam logic [5:0] BODY_END_TWO = 6'(START_TICKS + 2 * SLOT_TICKS);

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // Input item, first field in the highest bits.
  typedef struct packed {
    logic       dio_sense;
    logic       dot_on;
    logic [3:0] minute_ones;
    logic [3:0] minute_tens;
    logic [3:0] hour_ones;
    logic [3:0] hour_tens;
    logic       start_frame;
  } item_t;

  typedef struct packed {
    logic frame_done;
    logic waiting_ack;
    logic busy_res;
    logic dio_line;
    logic clk_line;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);

  typedef struct packed {
    logic [2:0] bit_idx;
    logic [1:0] phase;
  } bit_slot_t;

  typedef enum logic [1:0] {
    PH_CLK_LOW  = 2'd0,
    PH_DATA     = 2'd1,
    PH_CLK_HIGH = 2'd2
  } phase_e;

  // Common-cathode segment pattern; digits above nine show as nine.
  function automatic logic [7:0] seg_encode(input logic [3:0] d);
    logic [7:0] seg;
    case (d)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      default: seg = 8'h6f;
    endcase
    return seg;
  endfunction

  // Splits a tick offset below 24 into the bit number and the phase within that bit.
  function automatic bit_slot_t bit_slot(input logic [4:0] p);
    bit_slot_t slot;
    slot = '0;
    for (int i = 0; i < 8; i++) begin
      if (p >= 5'(3 * i)) begin
        slot.bit_idx = 3'(i);
        slot.phase   = 2'(p - 5'(3 * i));
      end
    end
    return slot;
  endfunction

endpackage

FILE: design/sswfw_in_reg.sv
// Input register of the frame writer: holds one tick item until the sequencer takes it.
// Depends on sswfw_pkg for the item type.
module sswfw_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sswfw_pkg::item_t  s_item,
  input  logic              advance,
  output logic              valid,
  output sswfw_pkg::item_t  item
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

FILE: design/sswfw_seq.sv
// Frame sequencer: line state, tick counters, segment store and the display control register.
// Works out one tick per step from the registered item; depends on sswfw_pkg.
module sswfw_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  sswfw_pkg::item_t   item,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output sswfw_pkg::result_t result
);

  logic       clk_level, clk_level_next;
  logic       dio_level, dio_level_next;
  logic [2:0] transaction_index, transaction_index_next;
  logic [5:0] tick_in_transaction, tick_in_transaction_next;
  logic       active, active_next;
  logic [7:0] display_control;
  logic [7:0] segment_bytes [4];

  logic                  start;
  logic                  act;
  logic [2:0]            tr;
  logic [5:0]            t;
  logic [5:0]            body_end;
  logic [5:0]            r;
  logic                  second_byte;
  logic [4:0]            p;
  logic [5:0]            s;
  logic [1:0]            seg_sel;
  logic [7:0]            cur_byte;
  sswfw_pkg::bit_slot_t  slot;
  logic                  wait_tick;
  logic                  hold;
  logic                  end_tr;
  logic                  done;

  assign start   = !active && item.start_frame;
  assign act     = active || start;
  assign tr      = start ? 3'd0 : transaction_index;
  assign t       = start ? 6'd0 : tick_in_transaction;
  assign seg_sel = 2'(tr - 3'd1);

  assign body_end = (tr != 3'd0 && tr < sswfw_pkg::LAST_TRANSACTION) ?
                    sswfw_pkg::BODY_END_TWO : sswfw_pkg::BODY_END_ONE;
  assign r           = t - 6'(sswfw_pkg::START_TICKS);
  assign second_byte = r >= 6'(sswfw_pkg::SLOT_TICKS);
  assign p           = second_byte ? 5'(r - 6'(sswfw_pkg::SLOT_TICKS)) : r[4:0];
  assign s           = t - body_end;
  assign slot        = sswfw_pkg::bit_slot(p);

  always_comb begin
    if (tr == 3'd0) begin
      cur_byte = sswfw_pkg::CMD_FIXED_ADDR;
    end else if (tr >= sswfw_pkg::LAST_TRANSACTION) begin
      cur_byte = display_control;
    end else if (!second_byte) begin
      cur_byte = sswfw_pkg::ADDR_BASE | {6'd0, seg_sel};
    end else begin
      cur_byte = segment_bytes[seg_sel];
    end
  end

  // Line levels and the end-of-transaction / acknowledge conditions for this tick.
  always_comb begin
    clk_level_next = clk_level;
    dio_level_next = dio_level;
    wait_tick      = 1'b0;
    hold           = 1'b0;
    end_tr         = 1'b0;
    if (act) begin
      if (t < 6'(sswfw_pkg::START_TICKS)) begin
        case (t[1:0])
          2'd0: begin
            clk_level_next = 1'b1;
            dio_level_next = 1'b1;
          end
          2'd1:    dio_level_next = 1'b0;
          default: clk_level_next = 1'b0;
        endcase
      end else if (t < body_end) begin
        if (p < 5'(sswfw_pkg::BIT_TICKS)) begin
          case (slot.phase)
            sswfw_pkg::PH_CLK_LOW: clk_level_next = 1'b0;
            sswfw_pkg::PH_DATA:    dio_level_next = cur_byte[slot.bit_idx];
            default:               clk_level_next = 1'b1;
          endcase
        end else if (p == 5'd24) begin
          clk_level_next = 1'b0;
        end else if (p == 5'd25) begin
          dio_level_next = 1'b1;
        end else if (p == 5'd26) begin
          clk_level_next = 1'b1;
        end else begin
          wait_tick = 1'b1;
          hold      = item.dio_sense;
        end
      end else begin
        case (s[1:0])
          2'd0: clk_level_next = 1'b0;
          2'd1: dio_level_next = 1'b0;
          2'd2: clk_level_next = 1'b1;
          default: begin
            dio_level_next = 1'b1;
            end_tr         = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    transaction_index_next   = tr;
    tick_in_transaction_next = t;
    active_next              = act;
    done                     = 1'b0;
    if (act) begin
      if (end_tr) begin
        tick_in_transaction_next = 6'd0;
        if (tr >= sswfw_pkg::LAST_TRANSACTION) begin
          done                   = 1'b1;
          active_next            = 1'b0;
          transaction_index_next = 3'd0;
        end else begin
          transaction_index_next = tr + 3'd1;
        end
      end else if (!hold) begin
        tick_in_transaction_next = t + 6'd1;
      end
    end
  end

  always_comb begin
    result.clk_line    = clk_level_next;
    result.dio_line    = dio_level_next;
    result.busy_res    = act;
    result.waiting_ack = wait_tick;
    result.frame_done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_level           <= 1'b1;
      dio_level           <= 1'b1;
      transaction_index   <= 3'd0;
      tick_in_transaction <= 6'd0;
      active              <= 1'b0;
    end else if (step) begin
      clk_level           <= clk_level_next;
      dio_level           <= dio_level_next;
      transaction_index   <= transaction_index_next;
      tick_in_transaction <= tick_in_transaction_next;
      active              <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_control <= sswfw_pkg::CONTROL_RESET;
    end else if (cfg_valid) begin
      display_control <= cfg_data;
    end
  end

  // The segment store is loaded whole when a frame starts, so it needs no reset.
  always_ff @(posedge clk) begin
    if (step && start) begin
      segment_bytes[0] <= sswfw_pkg::seg_encode(item.hour_tens);
      segment_bytes[1] <= sswfw_pkg::seg_encode(item.hour_ones) | {item.dot_on, 7'd0};
      segment_bytes[2] <= sswfw_pkg::seg_encode(item.minute_tens);
      segment_bytes[3] <= sswfw_pkg::seg_encode(item.minute_ones);
    end
  end

endmodule

FILE: design/sswfw_out_reg.sv
// Result register of the frame writer: holds one tick result until the sink takes it.
// Depends on sswfw_pkg for the result type.
module sswfw_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sswfw_pkg::result_t  result_in,
  output logic                can_load,
  output logic                m_tvalid,
  input  logic                m_tready,
  output sswfw_pkg::result_t  result
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= result_in;
    end
  end

endmodule

FILE: design/seven_segment_two_wire_frame_writer_unit.sv
// Two-wire seven-segment frame writer, top level.
// An input transfer passes through the input register and then the result register.
// Throughput: one tick item per cycle; the sequencer steps once per item it takes, and a
// result held by m_tready low stalls the input register behind it.
// Reset (rst, synchronous): lines high, no frame active, display control 0x8a, both registers empty.
// Depends on sswfw_pkg, sswfw_in_reg, sswfw_seq and sswfw_out_reg.
module seven_segment_two_wire_frame_writer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // start_frame, hour_tens, hour_ones, minute_tens, minute_ones, dot_on, dio_sense
  input  logic [sswfw_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // clk_line, dio_line, busy_res, waiting_ack
  output logic [sswfw_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // frame_done
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [7:0]                           cfg_data
);

  sswfw_pkg::item_t   s_item;
  sswfw_pkg::item_t   in_item;
  sswfw_pkg::result_t seq_result;
  sswfw_pkg::result_t out_result;
  logic               in_valid;
  logic               can_load;
  logic               advance;

  assign s_item    = sswfw_pkg::item_t'(s_tdata[sswfw_pkg::ITEM_W-1:0]);
  assign advance   = in_valid && can_load;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(sswfw_pkg::OUT_TDATA_W - sswfw_pkg::RESULT_W + 1){1'b0}},
                      out_result[sswfw_pkg::RESULT_W-2:0]};
  assign m_tlast   = out_result.frame_done;

  sswfw_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .advance  (advance),
    .valid    (in_valid),
    .item     (in_item)
  );

  sswfw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .result    (seq_result)
  );

  sswfw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (seq_result),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .result    (out_result)
  );

endmodule

FILE: design/sswfw_checker.sv
// Port-level checks for the frame writer, bound to the top level.
// Depends on sswfw_pkg and the assertion macro header.
`include "seven_segment_two_wire_frame_writer_unit_assert.svh"

module sswfw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [sswfw_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                              m_tlast,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  sswfw_pkg::result_t res;

  assign res = sswfw_pkg::result_t'({m_tlast, m_tdata[sswfw_pkg::RESULT_W-2:0]});

  // A stalled result keeps its value.
  `SSWFW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // Waiting for acknowledge only happens inside a frame.
  `SSWFW_ASSERT_NOW(a_wait_busy, m_tvalid && res.waiting_ack, res.busy_res)
  // The last tick of a frame is a stop: both lines released, no acknowledge wait.
  `SSWFW_ASSERT_NOW(a_done_stop, m_tvalid && res.frame_done, res.busy_res && !res.waiting_ack && res.clk_line && res.dio_line)
  // The configuration channel never stalls.
  `SSWFW_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind seven_segment_two_wire_frame_writer_unit sswfw_checker u_sswfw_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

FILE: verif/seven_segment_two_wire_frame_writer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-wire seven-segment frame writer.
// Drives tick items and control writes, predicts every line sample, and depends on sswfw_pkg.
module seven_segment_two_wire_frame_writer_unit_tb;

  localparam int STOP_TICKS      = 4;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int NOISE_ITEMS     = 60;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic [7:0] GLYPH [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                        8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [sswfw_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [sswfw_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                              m_tlast;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [7:0]                        cfg_data = '0;

  seven_segment_two_wire_frame_writer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow of the line sequencer.
  logic       line_clk = 1'b1;
  logic       line_dio = 1'b1;
  logic [2:0] xfer_idx = '0;
  logic [5:0] xfer_tick = '0;
  logic [7:0] seg_latch [4];
  logic       frame_busy = 1'b0;
  logic [7:0] brightness_ctrl = sswfw_pkg::CONTROL_RESET;

  sswfw_pkg::item_t   pending_ticks[$];
  sswfw_pkg::result_t expected_lines[$];
  int      queued_ticks = 0;
  int      accepted_ticks = 0;
  int      cfg_writes = 0;
  int      errors = 0;
  int      idle_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      tick_taken = 1'b0;

  function automatic logic [7:0] glyph_of(input logic [3:0] digit);
    return (digit > 4'd9) ? GLYPH[9] : GLYPH[digit];
  endfunction

  // Works out the line levels and flags that one tick produces.
  task automatic advance_display_lines(input sswfw_pkg::item_t it,
                                       output sswfw_pkg::result_t r);
    int   t, body_end, rel, slot, pos, bit_no;
    logic [7:0] byte_out;
    logic hold, end_xfer;
    r = '0;
    hold = 1'b0;
    end_xfer = 1'b0;
    if (!frame_busy && it.start_frame) begin
      seg_latch[0] = glyph_of(it.hour_tens);
      seg_latch[1] = glyph_of(it.hour_ones) | (it.dot_on ? 8'h80 : 8'h00);
      seg_latch[2] = glyph_of(it.minute_tens);
      seg_latch[3] = glyph_of(it.minute_ones);
      frame_busy = 1'b1;
      xfer_idx = '0;
      xfer_tick = '0;
    end
    if (frame_busy) begin
      t = xfer_tick;
      body_end = sswfw_pkg::START_TICKS + sswfw_pkg::SLOT_TICKS *
                 ((xfer_idx == 0 || xfer_idx >= sswfw_pkg::LAST_TRANSACTION) ? 1 : 2);
      r.busy_res = 1'b1;
      if (t < sswfw_pkg::START_TICKS) begin
        if (t == 0) begin
          line_clk = 1'b1;
          line_dio = 1'b1;
        end else if (t == 1) begin
          line_dio = 1'b0;
        end else begin
          line_clk = 1'b0;
        end
      end else if (t < body_end) begin
        rel  = t - sswfw_pkg::START_TICKS;
        slot = rel / sswfw_pkg::SLOT_TICKS;
        pos  = rel % sswfw_pkg::SLOT_TICKS;
        if (pos < sswfw_pkg::BIT_TICKS) begin
          bit_no = pos / 3;
          if (xfer_idx == 0) byte_out = sswfw_pkg::CMD_FIXED_ADDR;
          else if (xfer_idx >= sswfw_pkg::LAST_TRANSACTION) byte_out = brightness_ctrl;
          else if (slot == 0) byte_out = sswfw_pkg::ADDR_BASE + 8'(xfer_idx - 3'd1);
          else byte_out = seg_latch[2'(xfer_idx - 3'd1)];
          case (sswfw_pkg::phase_e'(2'(pos % 3)))
            sswfw_pkg::PH_CLK_LOW: line_clk = 1'b0;
            sswfw_pkg::PH_DATA:    line_dio = byte_out[bit_no];
            default:               line_clk = 1'b1;
          endcase
        end else if (pos == sswfw_pkg::BIT_TICKS) begin
          line_clk = 1'b0;
        end else if (pos == sswfw_pkg::BIT_TICKS + 1) begin
          line_dio = 1'b1;
        end else if (pos == sswfw_pkg::BIT_TICKS + 2) begin
          line_clk = 1'b1;
        end else begin
          r.waiting_ack = 1'b1;
          hold = it.dio_sense;
        end
      end else begin
        case (t - body_end)
          0:       line_clk = 1'b0;
          1:       line_dio = 1'b0;
          2:       line_clk = 1'b1;
          default: begin
            line_dio = 1'b1;
            end_xfer = 1'b1;
          end
        endcase
      end
      if (end_xfer) begin
        xfer_tick = '0;
        if (xfer_idx >= sswfw_pkg::LAST_TRANSACTION) begin
          r.frame_done = 1'b1;
          frame_busy = 1'b0;
          xfer_idx = '0;
        end else begin
          xfer_idx = xfer_idx + 3'd1;
        end
      end else if (!hold) begin
        xfer_tick = xfer_tick + 6'd1;
      end
    end
    r.clk_line = line_clk;
    r.dio_line = line_dio;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: inputs change on the falling edge only.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || tick_taken) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {{(sswfw_pkg::IN_TDATA_W - sswfw_pkg::ITEM_W){1'b0}},
                       pending_ticks.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: every transfer is seen on the rising edge.
  always @(posedge clk) begin
    sswfw_pkg::result_t                want;
    logic [sswfw_pkg::OUT_TDATA_W-1:0] want_data;
    logic                              out_xfer;
    if (!rst) begin
      tick_taken = s_tvalid && s_tready;
      out_xfer = m_tvalid && m_tready;
      if (tick_taken) begin
        advance_display_lines(sswfw_pkg::item_t'(s_tdata[sswfw_pkg::ITEM_W-1:0]), want);
        expected_lines.push_back(want);
        accepted_ticks++;
      end
      if (cfg_valid && cfg_ready) begin
        brightness_ctrl = cfg_data;
        cfg_writes++;
      end
      if (out_xfer) begin
        if (expected_lines.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, actual %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_lines.pop_front();
          want_data = {{(sswfw_pkg::OUT_TDATA_W - sswfw_pkg::RESULT_W + 1){1'b0}},
                       want[sswfw_pkg::RESULT_W-2:0]};
          if (m_tdata !== want_data || m_tlast !== want.frame_done) begin
            errors++;
            $display("%0t: mismatch, expected clk=%b dio=%b busy=%b ack=%b done=%b, actual %h last %b",
                     $time, want.clk_line, want.dio_line, want.busy_res, want.waiting_ack,
                     want.frame_done, m_tdata, m_tlast);
          end
        end
      end
      if (tick_taken || out_xfer || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  task automatic push_tick(input sswfw_pkg::item_t it);
    pending_ticks.push_back(it);
    queued_ticks++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_ticks != queued_ticks || expected_lines.size() != 0);
  endtask

  // Idle ticks with the data line acknowledging until no frame is in progress.
  task automatic settle_idle();
    sswfw_pkg::item_t it;
    wait_drained();
    while (frame_busy) begin
      repeat (16) begin
        it = sswfw_pkg::item_t'(sswfw_pkg::ITEM_W'($urandom));
        it.start_frame = 1'b0;
        it.dio_sense = 1'b0;
        push_tick(it);
      end
      wait_drained();
    end
  endtask

  task automatic write_control(input logic [7:0] value);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk);
    while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // One well-formed frame: ack ticks get a random number of held ticks before
  // the acknowledge, the rest of the fields are noise the block must ignore.
  task automatic queue_frame();
    sswfw_pkg::item_t it;
    int    len, hold;
    for (int tr = 0; tr <= sswfw_pkg::LAST_TRANSACTION; tr++) begin
      len = sswfw_pkg::START_TICKS + STOP_TICKS + sswfw_pkg::SLOT_TICKS *
            ((tr == 0 || tr == sswfw_pkg::LAST_TRANSACTION) ? 1 : 2);
      for (int t = 0; t < len; t++) begin
        it = sswfw_pkg::item_t'(sswfw_pkg::ITEM_W'($urandom));
        if (tr == 0 && t == 0) it.start_frame = 1'b1;
        else if (tr == sswfw_pkg::LAST_TRANSACTION && t == len - 1)
          it.start_frame = 1'($urandom_range(1));
        else it.start_frame = ($urandom_range(7) == 0);
        if (t >= sswfw_pkg::START_TICKS && t < len - STOP_TICKS &&
            (t - sswfw_pkg::START_TICKS) % sswfw_pkg::SLOT_TICKS ==
            sswfw_pkg::SLOT_TICKS - 1) begin
          if ($urandom_range(1) == 0) hold = 0;
          else if ($urandom_range(9) == 0) hold = $urandom_range(40);
          else hold = $urandom_range(3, 1);
          it.dio_sense = 1'b1;
          repeat (hold) push_tick(it);
          it.dio_sense = 1'b0;
        end
        push_tick(it);
      end
    end
    repeat ($urandom_range(3)) begin
      it = sswfw_pkg::item_t'(sswfw_pkg::ITEM_W'($urandom));
      it.start_frame = 1'b0;
      push_tick(it);
    end
  endtask

  initial begin
    sswfw_pkg::item_t it;
    int    target;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, a start with saturating and extreme digits and the
    // dot lit, then starts while busy that must be ignored.
    it = '0;
    push_tick(it);
    it.dio_sense = 1'b1;
    push_tick(it);
    it = '{dio_sense: 1'b0, dot_on: 1'b1, minute_ones: 4'd9, minute_tens: 4'd0,
           hour_ones: 4'd10, hour_tens: 4'd15, start_frame: 1'b1};
    push_tick(it);
    repeat (16) begin
      it = '1;
      it.dio_sense = 1'($urandom_range(1));
      push_tick(it);
    end
    it = '{dio_sense: 1'b0, dot_on: 1'b0, minute_ones: 4'd15, minute_tens: 4'd12,
           hour_ones: 4'd0, hour_tens: 4'd9, start_frame: 1'b1};
    push_tick(it);
    settle_idle();

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 68;
          write_control(8'h00);
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 11;
          write_control(8'hff);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_control(8'($urandom_range(255)));
        end
      endcase
      target = queued_ticks + ITEMS_PER_PHASE;
      while (queued_ticks < target) begin
        queue_frame();
        // Let the whole pipeline empty once after a frame.
        if (phase_no == 0) wait_drained();
      end
      // Broken sequences in the last phase: starts and acknowledges at random.
      if (phase_no == 2) begin
        repeat (NOISE_ITEMS) push_tick(sswfw_pkg::item_t'(sswfw_pkg::ITEM_W'($urandom)));
      end
      settle_idle();
    end

    repeat (20) @(negedge clk);
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
